// File: rtl/core/pimc_pkg.sv
// Shared types and constants for the press interval converter.
package pimc_pkg;

  localparam int unsigned COLUMNS_DEF    = 4;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned CFG_W          = 20;
  localparam int unsigned MS_W           = 32;
  localparam int unsigned MULT_W         = 30;   // 1000 * 20-bit den
  localparam int unsigned PROD_W         = 62;   // 32-bit frames * 30-bit mult
  localparam int unsigned TOT_W          = 63;
  localparam logic [9:0]  MS_PER_S       = 10'd1000;

  localparam logic [CFG_W-1:0] NUM_RST = 20'd60;
  localparam logic [CFG_W-1:0] DEN_RST = 20'd1;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic {
    REG_NUM = 1'b0,
    REG_DEN = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_ADD,
    PH_DIV
  } div_phase_t;

  // Per-lane request into the shared divider
  typedef struct packed {
    logic             act;     // lane wants a conversion
    logic [MS_W-1:0]  frames;
    logic [CFG_W-1:0] carry;
  } div_req_t;

endpackage

// File: rtl/core/pimc_divider.sv
// Sequential restoring divider: (frames*mult + carry) / num (num of 0 taken as 1), saturated to 32 bits.
module pimc_divider
  import pimc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MS_W-1:0]  frames,
  input  logic [CFG_W-1:0] carry_in,
  input  logic [CFG_W-1:0] num,
  input  logic [CFG_W-1:0] den,
  output logic             done,
  output logic [MS_W-1:0]  quot,
  output logic [CFG_W-1:0] rem
);

  div_phase_t        phase_r, phase_nxt;
  logic [MULT_W-1:0] mult_r;
  logic [TOT_W-1:0]  tot_r;
  logic [TOT_W-1:0]  q_r;
  logic [CFG_W:0]    rm_r;
  logic [CFG_W-1:0]  div_r;
  logic [CFG_W-1:0]  carry_r;
  logic [MS_W-1:0]   fr_r;
  logic [5:0]        cnt_r;
  logic [PROD_W-1:0] prod_r;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    shifted;

  assign shifted = {rm_r[CFG_W-1:0], tot_r[TOT_W-1]};
  assign trial   = shifted - {1'b0, div_r};

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (start) phase_nxt = PH_MUL;
      PH_MUL:  phase_nxt = PH_ADD;
      PH_ADD:  phase_nxt = PH_DIV;
      PH_DIV:  if (cnt_r == 6'd0) phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done    <= (phase_r == PH_DIV) && (cnt_r == 6'd0);
    end
    case (phase_r)
      PH_IDLE: begin
        fr_r    <= frames;
        carry_r <= carry_in;
        mult_r  <= MULT_W'(MS_PER_S) * MULT_W'(den);
        div_r   <= (num == '0) ? CFG_W'(1) : num;
      end
      PH_MUL: prod_r <= PROD_W'(fr_r) * PROD_W'(mult_r);
      PH_ADD: begin
        tot_r <= TOT_W'(prod_r) + TOT_W'(carry_r);
        rm_r  <= '0;
        q_r   <= '0;
        cnt_r <= 6'(TOT_W - 1);
      end
      default: begin
        tot_r <= {tot_r[TOT_W-2:0], 1'b0};
        if (!trial[CFG_W]) begin
          rm_r <= trial;
          q_r  <= {q_r[TOT_W-2:0], 1'b1};
        end else begin
          rm_r <= shifted;
          q_r  <= {q_r[TOT_W-2:0], 1'b0};
        end
        if (cnt_r != 6'd0) cnt_r <= cnt_r - 6'd1;
      end
    endcase
  end

  assign quot = (q_r[TOT_W-1:MS_W] != '0) ? {MS_W{1'b1}} : q_r[MS_W-1:0];
  assign rem  = rm_r[CFG_W-1:0];

endmodule

// File: rtl/core/pimc_lane.sv
// One column lane: edge detection, per-column state and request building.
module pimc_lane
  import pimc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  capture,    // item taken: latch edge decision
  input  logic                  is_end,
  input  logic                  held,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [TIME_WIDTH-1:0] earliest,   // earliest start, already updated
  input  logic                  commit,     // divider result for this lane ready
  input  logic [MS_W-1:0]       quot,
  input  logic [CFG_W-1:0]      rem,
  input  logic                  clear,      // end of stream finished
  output div_req_t              req,
  output logic                  emits,
  output kind_t                 kind,
  output logic [MS_W-1:0]       hold_ms,
  output logic [MS_W-1:0]       gap_ms
);

  logic                  pressed_r, has_seg_r;
  logic [TIME_WIDTH-1:0] start_r, rel_r;
  logic [MS_W-1:0]       pend_r;
  logic [CFG_W-1:0]      carry_r;
  // decision latched at capture
  logic                  op_press_r, op_rel_r, op_end_r, first_r;
  logic [MS_W-1:0]       res_r;

  logic [TIME_WIDTH-1:0] diff;

  always_comb begin
    diff = '0;
    if (op_end_r || op_rel_r) diff = now - start_r;
    else if (first_r)         diff = now - earliest;
    else                      diff = now - rel_r;
  end

  assign req.act    = (op_press_r) || op_rel_r || (op_end_r && pressed_r);
  assign req.frames = MS_W'(diff);
  assign req.carry  = (op_press_r && first_r) ? '0 : carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r  <= 1'b0;
      has_seg_r  <= 1'b0;
      start_r    <= '0;
      rel_r      <= '0;
      pend_r     <= '0;
      carry_r    <= '0;
      op_press_r <= 1'b0;
      op_rel_r   <= 1'b0;
      op_end_r   <= 1'b0;
      first_r    <= 1'b0;
    end else if (capture) begin
      op_end_r   <= is_end;
      op_press_r <= !is_end && held && !pressed_r;
      op_rel_r   <= !is_end && !held && pressed_r;
      first_r    <= !has_seg_r;
    end else if (clear) begin
      pressed_r <= 1'b0;
      has_seg_r <= 1'b0;
      start_r   <= '0;
      rel_r     <= '0;
      pend_r    <= '0;
      carry_r   <= '0;
      op_end_r  <= 1'b0;
    end else if (commit) begin
      res_r <= quot;
      if (op_press_r) begin
        if (!first_r) carry_r <= rem;
        has_seg_r <= 1'b1;
        pressed_r <= 1'b1;
        start_r   <= now;
      end else if (op_rel_r) begin
        pend_r    <= quot;
        carry_r   <= rem;
        rel_r     <= now;
        pressed_r <= 1'b0;
        start_r   <= '0;
      end
    end
  end

  // Output view valid after all commits of the item
  always_comb begin
    emits   = 1'b0;
    kind    = KIND_PAIR;
    hold_ms = '0;
    gap_ms  = '0;
    if (op_end_r) begin
      emits = 1'b1;
      if (pressed_r)      hold_ms = res_r;
      else if (has_seg_r) hold_ms = pend_r;
      else                kind    = KIND_EMPTY;
    end else if (op_press_r) begin
      emits = 1'b1;
      if (first_r) begin
        kind    = KIND_START;
        hold_ms = res_r;
      end else begin
        hold_ms = pend_r;
        gap_ms  = res_r;
      end
    end
  end

endmodule

// File: rtl/core/press_interval_to_ms_converter.sv
// Top level: config port, lanes, shared divider and result merging.
// Usage:
//  in_*  : one item per video frame; tdata = column_mask[3:0] (zero padded),
//          tuser = req_type (0 frame sample, 1 end of stream).
//  out_* : up to COLUMNS results per item in ascending column order; tdata
//          carries column, hold and gap, tuser the kind; tlast marks the
//          last result of an item.
//  cfg_* : APB port, rate numerator at 0x0, rate denominator at 0x4.
// Timing: after the item is taken the lanes are walked in column order; a lane
//  with nothing to convert is passed over, a lane that uses the shared divider
//  waits for it to start, multiply, add, form 63 quotient bits and return the
//  result. The merge stage then visits the columns in order, waiting on
//  out_tready for each column that emits a result. A new item is taken only
//  after every lane and result of the last one is through; the single shared
//  divider bounds the throughput.
// Reset: all stream state clears, frame count restarts at 1, registers go to
//  60 and 1. A stalled receiver holds the output item; no new input item is
//  taken until every result of the current one has been delivered. An end of
//  stream item clears the stream state after its results.
module press_interval_to_ms_converter
  import pimc_pkg::*;
#(
  parameter int unsigned COLUMNS    = COLUMNS_DEF,
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [COLUMNS-1:0] column_mask, zero padded
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // column[1:0], hold_ms[33:2], gap_ms[65:34], zero padded
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,  // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [CFG_W-1:0] num_r, den_r;
  reg_idx_t         ridx;
  assign ridx       = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  always_comb begin
    case (ridx)
      REG_NUM: cfg_prdata = 32'(num_r);
      REG_DEN: cfg_prdata = 32'(den_r);
      default: cfg_prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= NUM_RST;
      den_r <= DEN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_NUM: num_r <= cfg_pwdata[CFG_W-1:0];
        REG_DEN: den_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [TIME_WIDTH-1:0] frame_r, earliest_r;
  logic                  earliest_v_r;
  logic                  is_end_r;
  logic [CW-1:0]         col_r;
  logic                  busy_r;     // divider running
  logic                  capture, clear;
  logic                  take;

  div_req_t              req    [COLUMNS];
  logic [COLUMNS-1:0]    emits, act;
  kind_t                 kinds  [COLUMNS];
  logic [MS_W-1:0]       holds  [COLUMNS];
  logic [MS_W-1:0]       gaps   [COLUMNS];
  logic [COLUMNS-1:0]    commit;

  logic [COLUMNS-1:0]    mask;
  logic                  any_new;
  logic [TIME_WIDTH-1:0] earliest_now;

  assign mask  = in_tdata[COLUMNS-1:0];
  assign take  = in_tvalid && in_tready;
  assign capture = take;

  always_comb begin
    any_new = 1'b0;
    for (int i = 0; i < COLUMNS; i++) any_new = any_new | mask[i];
  end
  // lanes see the earliest start as it stands after this item
  assign earliest_now = earliest_v_r ? earliest_r : frame_r;

  logic div_start, div_done;
  logic [MS_W-1:0]  quot;
  logic [CFG_W-1:0] rem;

  for (genvar g = 0; g < COLUMNS; g++) begin : g_lane
    pimc_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .capture  (capture),
      .is_end   (in_tuser),
      .held     (mask[g]),
      .now      (frame_r),
      .earliest (earliest_r),
      .commit   (commit[g]),
      .quot     (quot),
      .rem      (rem),
      .clear    (clear),
      .req      (req[g]),
      .emits    (emits[g]),
      .kind     (kinds[g]),
      .hold_ms  (holds[g]),
      .gap_ms   (gaps[g])
    );
    assign act[g] = req[g].act;
  end

  pimc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .frames   (req[col_r].frames),
    .carry_in (req[col_r].carry),
    .num      (num_r),
    .den      (den_r),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  logic col_last;
  assign col_last = (col_r == CW'(COLUMNS - 1));

  logic later_emit;
  always_comb begin
    later_emit = 1'b0;
    for (int i = 0; i < COLUMNS; i++)
      if (CW'(i) > col_r && emits[i]) later_emit = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (take) state_nxt = ST_DIV;
      ST_DIV:  if (!busy_r && !act[col_r] && col_last) state_nxt = ST_EMIT;
               else if (div_done && col_last) state_nxt = ST_EMIT;
      ST_EMIT: if (!emits[col_r] || out_tready) begin
                 if (col_last) state_nxt = ST_IDLE;
               end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    div_start  = (state_r == ST_DIV) && !busy_r && act[col_r];
    commit     = '0;
    if (state_r == ST_DIV && div_done) commit[col_r] = 1'b1;
    out_tvalid = (state_r == ST_EMIT) && emits[col_r];
    out_tlast  = !later_emit;
    out_tdata  = {6'd0, gaps[col_r], holds[col_r], 2'(col_r)};
    out_tuser  = kinds[col_r];
    clear      = (state_r == ST_EMIT) && (state_nxt == ST_IDLE) && is_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      col_r        <= '0;
      busy_r       <= 1'b0;
      frame_r      <= TIME_WIDTH'(1);
      earliest_r   <= '0;
      earliest_v_r <= 1'b0;
      is_end_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (take) begin
          col_r    <= '0;
          is_end_r <= in_tuser;
          if (!in_tuser && any_new) begin
            earliest_r   <= earliest_now;
            earliest_v_r <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_start) busy_r <= 1'b1;
          if (div_done) busy_r <= 1'b0;
          if ((div_done || (!busy_r && !act[col_r])) && !col_last)
            col_r <= col_r + CW'(1);
          if (state_nxt == ST_EMIT) col_r <= '0;
        end
        ST_EMIT: if ((!emits[col_r] || out_tready) && !col_last)
          col_r <= col_r + CW'(1);
        default: ;
      endcase
      if (state_r == ST_EMIT && state_nxt == ST_IDLE) begin
        if (is_end_r) begin
          frame_r      <= TIME_WIDTH'(1);
          earliest_r   <= '0;
          earliest_v_r <= 1'b0;
        end else begin
          frame_r <= frame_r + TIME_WIDTH'(1);
        end
      end
    end
  end

endmodule
